FILE: hw/rtl/half_precision_format_converter_assert.svh
// Assertion macros for the half precision format converter.
// Depends on nothing; included by the RTL files that assert.
`ifndef HALF_PRECISION_FORMAT_CONVERTER_ASSERT_SVH
`define HALF_PRECISION_FORMAT_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HPFC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define HPFC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HPFC_ASSERT_IMP(label, clk, rst_n, a, c)
`define HPFC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hw/rtl/hpfc_pkg.sv
// Shared types and constants for the half precision format converter.
// No dependencies.
package hpfc_pkg;
  typedef logic [1:0] op_t;
  localparam op_t OP_H2S = 2'd0;
  localparam op_t OP_H2D = 2'd1;
  localparam op_t OP_S2H = 2'd2;
  localparam op_t OP_D2H = 2'd3;
  localparam logic [15:0] HALF_QNAN = 16'h7e00;
  localparam logic [15:0] HALF_INF  = 16'h7c00;
endpackage

FILE: hw/rtl/half_precision_format_converter.sv
// Half precision format converter: binary16 <-> binary32/binary64.
// Uses hpfc_pkg and half_precision_format_converter_assert.svh.
//
// Usage: drive in_operation and in_source_bits with start high; the item
// transfers at the clock edge where start is high and busy is low. busy is
// tied low, so one item can transfer every cycle.
// Two register stages: the operands are captured in an input register, the
// conversion (widening with leading-zero normalization, or narrowing with
// round to nearest even) is one combinational pass, and the result lands in
// the output register. out_valid pulses one cycle once the item has passed
// both registers; out_result_bits is valid while out_valid is high.
// Throughput: one item per cycle.
// Reset (rst_n low, synchronous) clears the valid bits; no result is emitted
// for items in flight. The receiver cannot stall: every result is presented
// for exactly one cycle and must be taken then.
module half_precision_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_source_bits,
  output logic        out_valid,
  output logic [63:0] out_result_bits
);
  `include "half_precision_format_converter_assert.svh"

  logic              vld_r, ovld_r;
  hpfc_pkg::op_t     op_r;
  logic [63:0]       src_r, res_r;
  logic [63:0]       res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= start;
      ovld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= in_operation;
      src_r <= in_source_bits;
    end
    if (vld_r) res_r <= res_nxt;
  end

  // ---------------- widening ----------------
  logic        h_sign;
  logic [4:0]  h_exp;
  logic [9:0]  h_frac;
  logic [3:0]  lz;
  logic [9:0]  nfrac;
  logic [31:0] s_res;
  logic [63:0] d_res;

  always_comb begin
    h_sign = src_r[15];
    h_exp  = src_r[14:10];
    h_frac = src_r[9:0];
    lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (h_frac[i]) lz = 4'(9 - i);
    end
    // shift leading one out of the field
    nfrac = 10'(h_frac << (lz + 4'd1));
    if (h_exp == 5'h1f) begin
      s_res = {h_sign, 8'hff, h_frac, 13'd0};
      d_res = {h_sign, 11'h7ff, h_frac, 42'd0};
    end else if (h_exp == 5'd0) begin
      if (h_frac == 10'd0) begin
        s_res = {h_sign, 31'd0};
        d_res = {h_sign, 63'd0};
      end else begin
        s_res = {h_sign, 8'(8'd112 - {4'd0, lz}), nfrac, 13'd0};
        d_res = {h_sign, 11'(11'd1008 - {7'd0, lz}), nfrac, 42'd0};
      end
    end else begin
      s_res = {h_sign, 8'({3'd0, h_exp} + 8'd112), h_frac, 13'd0};
      d_res = {h_sign, 11'({6'd0, h_exp} + 11'd1008), h_frac, 42'd0};
    end
  end

  // ---------------- narrowing ----------------
  // Both sources map to sign, 11-bit exponent, 52-bit fraction.
  logic        w_sign, w_nan, w_big, w_isinf_exp, w_normal;
  logic [11:0] w_exp;        // rebiased to a 1023 bias
  logic [52:0] w_frac;
  logic        w_zero_exp;
  logic signed [13:0] cand;
  logic [13:0] shift;
  logic [53:0] sig;
  logic [53:0] den;
  logic        sticky;
  logic [11:0] kept;
  logic        rnd;
  logic [15:0] mag;

  always_comb begin
    if (op_r == hpfc_pkg::OP_S2H) begin
      w_sign      = src_r[31];
      w_isinf_exp = (src_r[30:23] == 8'hff);
      w_zero_exp  = (src_r[30:23] == 8'd0);
      w_exp       = 12'({4'd0, src_r[30:23]} + 12'd896);
      w_frac      = {1'b0, src_r[22:0], 29'd0};
    end else begin
      w_sign      = src_r[63];
      w_isinf_exp = (src_r[62:52] == 11'h7ff);
      w_zero_exp  = (src_r[62:52] == 11'd0);
      w_exp       = {1'b0, src_r[62:52]};
      w_frac      = {1'b0, src_r[51:0]};
    end
    w_normal = !w_zero_exp;
    w_nan    = w_isinf_exp && (w_frac != 53'd0);
    cand     = $signed({2'b00, w_exp}) - 14'sd1008;
    w_big    = cand >= 14'sd31;
    // subnormal shift (only used when cand < 1)
    shift = w_normal ? 14'(14'sd1 - cand) : 14'd0;
    sig   = {1'b0, w_normal, w_frac[51:0]};
    if (w_zero_exp) begin
      // source subnormal: far below half range
      den    = 54'd0;
      sticky = (w_frac != 53'd0);
    end else if (shift > 14'd53) begin
      den = 54'd0;
      sticky = 1'b1;
    end else begin
      den    = sig >> shift[5:0];
      sticky = ((sig & ~(54'h3fffffffffffff << shift[5:0])) != 54'd0);
    end
    den[0] = den[0] | sticky;
    if (cand >= 14'sd1 && !w_big) begin
      kept = {2'b0, w_frac[51:42]};
      rnd  = w_frac[41] && ((w_frac[40:0] != 41'd0) || w_frac[42]);
      mag  = 16'({cand[4:0], 10'd0} + {5'd0, kept[9:0]} + {15'd0, rnd});
    end else if (w_nan) begin
      mag = hpfc_pkg::HALF_QNAN | {7'd0, w_frac[50:42]};
      kept = 12'd0; rnd = 1'b0;
    end else if (w_big) begin
      mag = hpfc_pkg::HALF_INF;
      kept = 12'd0; rnd = 1'b0;
    end else begin
      kept = den[53:42];
      rnd  = den[41] && ((den[40:0] != 41'd0) || den[42]);
      mag  = 16'(kept + {11'd0, rnd});
    end
    // round carry into exponent 31 yields 0x7c00 naturally
  end

  always_comb begin
    unique case (op_r)
      hpfc_pkg::OP_H2S: res_nxt = {32'd0, s_res};
      hpfc_pkg::OP_H2D: res_nxt = d_res;
      default:          res_nxt = {48'd0, w_sign, mag[14:0]};
    endcase
  end

  assign out_valid       = ovld_r;
  assign out_result_bits = res_r;

  `HPFC_ASSERT_NXT(a_pipe, clk, rst_n, start, vld_r)
  `HPFC_ASSERT_NXT(a_out, clk, rst_n, vld_r, out_valid)
  `HPFC_ASSERT_IMP(a_nobusy, clk, rst_n, 1'b1, !busy)
  `HPFC_ASSERT_IMP(a_s2h_hi, clk, rst_n,
    out_valid && $past(op_r) == hpfc_pkg::OP_S2H, out_result_bits[63:16] == 48'd0)
endmodule
